// ===== sv/mef_pkg.sv =====
// ----------------------------------------------------------------------------
// mef_pkg
// Shared types and constants of the magnetoelastic field and energy block:
// register indexes, sequencer step codes and the command and status groups.
// ----------------------------------------------------------------------------
package mef_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int NUM_CELLS_W = 25;
  localparam int STEP_W      = 4;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t CFG_FIELD_COEF_NORMAL  = 3'd0;
  localparam cfg_index_t CFG_FIELD_COEF_SHEAR   = 3'd1;
  localparam cfg_index_t CFG_ENERGY_COEF_NORMAL = 3'd2;
  localparam cfg_index_t CFG_ENERGY_COEF_SHEAR  = 3'd3;
  localparam cfg_index_t CFG_CELL_VOLUME        = 3'd4;
  localparam cfg_index_t CFG_NUM_CELLS          = 3'd5;
  localparam cfg_index_t CFG_FIELD_ENABLE       = 3'd6;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_FNORM  = 4'd0;
  localparam step_t STEP_FSH1   = 4'd1;
  localparam step_t STEP_FSH2   = 4'd2;
  localparam step_t STEP_SQ     = 4'd3;
  localparam step_t STEP_CROSS  = 4'd4;
  localparam step_t STEP_ENORM  = 4'd5;
  localparam step_t STEP_ESHEAR = 4'd6;
  localparam step_t STEP_FCN    = 4'd7;
  localparam step_t STEP_FCS    = 4'd8;
  localparam step_t STEP_ECOEF  = 4'd9;
  localparam step_t STEP_CELL   = 4'd10;
  localparam step_t STEP_ACCUM  = 4'd11;
  localparam step_t STEP_VOL    = 4'd12;
  localparam step_t STEP_TOTAL  = 4'd13;

  typedef struct packed {
    logic  load_in;
    logic  run;
    step_t step;
    logic  load_out;
  } mef_cmd_t;

  typedef struct packed {
    logic last;
  } mef_sts_t;

endpackage

// ===== sv/mef_ctrl.sv =====
// ----------------------------------------------------------------------------
// mef_ctrl
// Sequencer of the block: accepts a cell, steps the datapath through its
// product steps and loads the output register when it is free.
// ----------------------------------------------------------------------------
module mef_ctrl
  import mef_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output mef_cmd_t cmd,
  input  mef_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  step_t  step, step_next;
  logic   out_valid_next;
  logic   load_out;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_RUN;
          step_next  = STEP_FNORM;
        end
      end
      S_RUN: begin
        if ((step == STEP_ACCUM && !sts.last) || step == STEP_TOTAL) begin
          state_next = S_DONE;
        end else begin
          step_next = step + 4'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_FNORM;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  assign cmd.load_in  = in_valid && (state == S_IDLE);
  assign cmd.run      = (state == S_RUN);
  assign cmd.step     = step;
  assign cmd.load_out = load_out;

endmodule

// ===== sv/mef_datapath.sv =====
// ----------------------------------------------------------------------------
// mef_datapath
// Configuration registers, three shared multiplier lanes, the intermediate
// registers of the field and energy terms, the energy accumulator, the cell
// counter and the output register.
// ----------------------------------------------------------------------------
module mef_datapath
  import mef_pkg::*;
#(
  parameter int CELL_COUNT_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  cfg_index_t         cfg_index,
  input  logic        [31:0] cfg_data,
  input  mef_cmd_t           cmd,
  output mef_sts_t           sts,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic signed [15:0] mag_z,
  input  logic signed [31:0] strain_xx,
  input  logic signed [31:0] strain_yy,
  input  logic signed [31:0] strain_zz,
  input  logic signed [31:0] strain_xy,
  input  logic signed [31:0] strain_xz,
  input  logic signed [31:0] strain_yz,
  input  logic signed [31:0] field_in_x,
  input  logic signed [31:0] field_in_y,
  input  logic signed [31:0] field_in_z,
  output logic signed [31:0] field_out_x,
  output logic signed [31:0] field_out_y,
  output logic signed [31:0] field_out_z,
  output logic signed [63:0] energy_total,
  output logic               energy_valid
);

  localparam int TW = (CELL_COUNT_BITS + 1 > NUM_CELLS_W) ? CELL_COUNT_BITS + 1 : NUM_CELLS_W;

  function automatic logic signed [32:0] sx16(input logic signed [15:0] v);
    sx16 = {{17{v[15]}}, v};
  endfunction

  function automatic logic signed [32:0] sx32(input logic signed [31:0] v);
    sx32 = {v[31], v};
  endfunction

  logic signed [31:0] field_coef_normal;
  logic signed [31:0] field_coef_shear;
  logic signed [31:0] energy_coef_normal;
  logic signed [31:0] energy_coef_shear;
  logic        [31:0] cell_volume;
  logic [NUM_CELLS_W-1:0] num_cells;
  logic               field_enable;

  logic signed [15:0] m_q [3];
  logic signed [31:0] en_q [3];
  logic signed [31:0] exy_q, exz_q, eyz_q;
  logic signed [31:0] h_q [3];

  logic signed [32:0] op_a [3];
  logic signed [32:0] op_b [3];
  logic signed [65:0] prod [3];

  logic signed [31:0] nrm [3];
  logic signed [47:0] sh [3];
  logic signed [32:0] shr [3];
  logic signed [31:0] sq [3];
  logic signed [31:0] cr [3];
  logic signed [31:0] en_term [3];
  logic signed [31:0] es_term [3];
  logic signed [63:0] fn [3];
  logic signed [33:0] fs [3];
  logic signed [31:0] fo [3];
  logic signed [50:0] cell_energy;
  logic signed [63:0] accum;
  logic        [63:0] total;
  logic               last_flag;
  logic [CELL_COUNT_BITS-1:0] cell_counter;

  logic signed [48:0] shr_sum [3];
  logic signed [63:0] fsum [3];
  logic signed [34:0] hsum [3];
  logic signed [31:0] fo_next [3];
  logic signed [31:0] nsum, ssum;
  logic signed [63:0] esum;
  logic signed [64:0] acc_sum;
  logic signed [63:0] accum_next;
  logic        [63:0] acc_mag;
  logic        [63:0] vol_prod;
  logic        [63:0] total_next;

  logic [CELL_COUNT_BITS:0] cnt_inc;
  logic [TW-1:0]            inc_w, tgt_w;
  logic                     last_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_coef_normal  <= '0;
      field_coef_shear   <= '0;
      energy_coef_normal <= '0;
      energy_coef_shear  <= '0;
      cell_volume        <= '0;
      num_cells          <= NUM_CELLS_W'(1);
      field_enable       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FIELD_COEF_NORMAL:  field_coef_normal  <= cfg_data;
        CFG_FIELD_COEF_SHEAR:   field_coef_shear   <= cfg_data;
        CFG_ENERGY_COEF_NORMAL: energy_coef_normal <= cfg_data;
        CFG_ENERGY_COEF_SHEAR:  energy_coef_shear  <= cfg_data;
        CFG_CELL_VOLUME:        cell_volume        <= cfg_data;
        CFG_NUM_CELLS:          num_cells          <= cfg_data[NUM_CELLS_W-1:0];
        CFG_FIELD_ENABLE:       field_enable       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      m_q[0]  <= mag_x;
      m_q[1]  <= mag_y;
      m_q[2]  <= mag_z;
      en_q[0] <= strain_xx;
      en_q[1] <= strain_yy;
      en_q[2] <= strain_zz;
      exy_q   <= strain_xy;
      exz_q   <= strain_xz;
      eyz_q   <= strain_yz;
      h_q[0]  <= field_in_x;
      h_q[1]  <= field_in_y;
      h_q[2]  <= field_in_z;
    end
  end

  assign nsum = en_term[0] + en_term[1] + en_term[2];
  assign ssum = es_term[0] + es_term[1] + es_term[2];
  assign acc_mag = accum[63] ? (64'd0 - accum) : accum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_a[i] = '0;
      op_b[i] = '0;
    end
    case (cmd.step)
      STEP_FNORM: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = sx16(m_q[i]);
          op_b[i] = sx32(en_q[i]);
        end
      end
      STEP_FSH1: begin
        op_a[0] = sx16(m_q[1]); op_b[0] = sx32(exy_q);
        op_a[1] = sx16(m_q[0]); op_b[1] = sx32(exy_q);
        op_a[2] = sx16(m_q[0]); op_b[2] = sx32(exz_q);
      end
      STEP_FSH2: begin
        op_a[0] = sx16(m_q[2]); op_b[0] = sx32(exz_q);
        op_a[1] = sx16(m_q[2]); op_b[1] = sx32(eyz_q);
        op_a[2] = sx16(m_q[1]); op_b[2] = sx32(eyz_q);
      end
      STEP_SQ: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = sx16(m_q[i]);
          op_b[i] = sx16(m_q[i]);
        end
      end
      STEP_CROSS: begin
        op_a[0] = sx16(m_q[0]); op_b[0] = sx16(m_q[1]);
        op_a[1] = sx16(m_q[1]); op_b[1] = sx16(m_q[2]);
        op_a[2] = sx16(m_q[0]); op_b[2] = sx16(m_q[2]);
      end
      STEP_ENORM: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = sx32(sq[i]);
          op_b[i] = sx32(en_q[i]);
        end
      end
      STEP_ESHEAR: begin
        op_a[0] = sx32(cr[0]); op_b[0] = sx32(exy_q);
        op_a[1] = sx32(cr[1]); op_b[1] = sx32(eyz_q);
        op_a[2] = sx32(cr[2]); op_b[2] = sx32(exz_q);
      end
      STEP_FCN: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = sx32(field_coef_normal);
          op_b[i] = sx32(nrm[i]);
        end
      end
      STEP_FCS: begin
        for (int i = 0; i < 3; i++) begin
          op_a[i] = sx32(field_coef_shear);
          op_b[i] = shr[i];
        end
      end
      STEP_ECOEF: begin
        op_a[0] = sx32(energy_coef_normal); op_b[0] = sx32(nsum);
        op_a[1] = sx32(energy_coef_shear);  op_b[1] = sx32(ssum);
      end
      STEP_VOL: begin
        op_a[0] = {1'b0, acc_mag[63:32]}; op_b[0] = {1'b0, cell_volume};
        op_a[1] = {1'b0, acc_mag[31:0]};  op_b[1] = {1'b0, cell_volume};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod[i] <= op_a[i] * op_b[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shr_sum[i] = {sh[i][47], sh[i]} + prod[i][48:0];
      fsum[i]    = fn[i] + prod[i][63:0];
      hsum[i]    = {{3{h_q[i][31]}}, h_q[i]} + {fs[i][33], fs[i]};
      if (!field_enable) begin
        fo_next[i] = h_q[i];
      end else if (hsum[i][34:31] != {4{hsum[i][34]}}) begin
        fo_next[i] = hsum[i][34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        fo_next[i] = hsum[i][31:0];
      end
    end
  end

  assign esum    = prod[0][63:0] + prod[1][63:0];
  assign acc_sum = {accum[63], accum} + {{14{cell_energy[50]}}, cell_energy};

  always_comb begin
    if (acc_sum[64] != acc_sum[63]) begin
      accum_next = acc_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      accum_next = acc_sum[63:0];
    end
  end

  assign vol_prod = prod[0][63:0] + {32'd0, prod[1][63:32]};

  always_comb begin
    if (!accum[63]) begin
      total_next = vol_prod[63] ? 64'h7FFF_FFFF_FFFF_FFFF : vol_prod;
    end else begin
      total_next = vol_prod[63] ? 64'h8000_0000_0000_0000 : (64'd0 - vol_prod);
    end
  end

  assign cnt_inc  = {1'b0, cell_counter} + {{CELL_COUNT_BITS{1'b0}}, 1'b1};
  assign inc_w    = TW'(cnt_inc);
  assign tgt_w    = (num_cells == '0) ? TW'(1) : TW'(num_cells);
  assign last_now = (inc_w >= tgt_w) || cnt_inc[CELL_COUNT_BITS];
  assign sts.last = last_now;

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      case (cmd.step)
        STEP_FSH1: begin
          for (int i = 0; i < 3; i++) nrm[i] <= prod[i][47:16];
        end
        STEP_FSH2: begin
          for (int i = 0; i < 3; i++) sh[i] <= prod[i][47:0];
        end
        STEP_SQ: begin
          for (int i = 0; i < 3; i++) shr[i] <= shr_sum[i][48:16];
        end
        STEP_CROSS: begin
          for (int i = 0; i < 3; i++) sq[i] <= prod[i][31:0];
        end
        STEP_ENORM: begin
          for (int i = 0; i < 3; i++) cr[i] <= prod[i][31:0];
        end
        STEP_ESHEAR: begin
          for (int i = 0; i < 3; i++) en_term[i] <= prod[i][63:32];
        end
        STEP_FCN: begin
          for (int i = 0; i < 3; i++) es_term[i] <= prod[i][63:32];
        end
        STEP_FCS: begin
          for (int i = 0; i < 3; i++) fn[i] <= prod[i][63:0];
        end
        STEP_ECOEF: begin
          for (int i = 0; i < 3; i++) fs[i] <= fsum[i][63:30];
        end
        STEP_CELL: begin
          cell_energy <= esum[63:13];
          for (int i = 0; i < 3; i++) fo[i] <= fo_next[i];
        end
        STEP_TOTAL: begin
          total <= total_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum        <= '0;
      cell_counter <= '0;
      last_flag    <= 1'b0;
    end else if (cmd.run && cmd.step == STEP_ACCUM) begin
      accum        <= accum_next;
      last_flag    <= last_now;
      cell_counter <= last_now ? '0 : cnt_inc[CELL_COUNT_BITS-1:0];
    end else if (cmd.run && cmd.step == STEP_TOTAL) begin
      accum <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      field_out_x  <= fo[0];
      field_out_y  <= fo[1];
      field_out_z  <= fo[2];
      energy_total <= last_flag ? total : 64'd0;
      energy_valid <= last_flag;
    end
  end

endmodule

// ===== sv/magnetoelastic_field_energy.sv =====
// ----------------------------------------------------------------------------
// magnetoelastic_field_energy
// Cubic magnetoelastic effective field and pass energy, one cell per item.
// One cell is worked at a time; the three multiplier lanes are stepped
// through twelve sequencer steps, fourteen on the cell that closes a pass,
// which scales the sum by volume. A new cell is taken only once the result
// of the cell before it is loaded into the output register.
// The next cell is taken while the previous result waits in the output register.
// Synchronous reset clears the accumulator, the cell counter, the output
// valid and sets the configuration registers to their reset values; both
// input channels are held off while reset is high.
// ----------------------------------------------------------------------------
module magnetoelastic_field_energy
  import mef_pkg::*;
#(
  parameter int CELL_COUNT_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic signed [15:0] mag_z,
  input  logic signed [31:0] strain_xx,
  input  logic signed [31:0] strain_yy,
  input  logic signed [31:0] strain_zz,
  input  logic signed [31:0] strain_xy,
  input  logic signed [31:0] strain_xz,
  input  logic signed [31:0] strain_yz,
  input  logic signed [31:0] field_in_x,
  input  logic signed [31:0] field_in_y,
  input  logic signed [31:0] field_in_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] field_out_x,
  output logic signed [31:0] field_out_y,
  output logic signed [31:0] field_out_z,
  output logic signed [63:0] energy_total,
  output logic               energy_valid
);

  mef_cmd_t cmd;
  mef_sts_t sts;

  assign cfg_ready = !rst;

  mef_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  mef_datapath #(
    .CELL_COUNT_BITS (CELL_COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .mag_x        (mag_x),
    .mag_y        (mag_y),
    .mag_z        (mag_z),
    .strain_xx    (strain_xx),
    .strain_yy    (strain_yy),
    .strain_zz    (strain_zz),
    .strain_xy    (strain_xy),
    .strain_xz    (strain_xz),
    .strain_yz    (strain_yz),
    .field_in_x   (field_in_x),
    .field_in_y   (field_in_y),
    .field_in_z   (field_in_z),
    .field_out_x  (field_out_x),
    .field_out_y  (field_out_y),
    .field_out_z  (field_out_z),
    .energy_total (energy_total),
    .energy_valid (energy_valid)
  );

endmodule

// ===== sv/mef_checker.sv =====
// ----------------------------------------------------------------------------
// mef_checker
// Port-level checks of the magnetoelastic field and energy block, attached
// to the top level by a bind statement.
// ----------------------------------------------------------------------------
module mef_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] field_out_x,
  input logic signed [63:0] energy_total,
  input logic               energy_valid
);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall ##11 in_stall)
    else $error("input taken again too soon after a transfer");

  a_no_output_on_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared right after an input transfer");

  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !energy_valid) |-> (energy_total == 64'd0))
    else $error("energy total nonzero outside the end of a pass");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(field_out_x) && $stable(energy_total)))
    else $error("stalled result changed");

endmodule

bind magnetoelastic_field_energy mef_checker u_mef_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .field_out_x  (field_out_x),
  .energy_total (energy_total),
  .energy_valid (energy_valid)
);
